// ----- rtl/core/lcw_pkg.sv -----
// ----------------------------------------------------------------------------
// lcw_pkg
// Types and constants shared by the load cell weigh controller modules.
// ----------------------------------------------------------------------------
package lcw_pkg;

  // Divider geometry: Q.32 quotient of a 24-bit difference over a 40-bit divisor
  localparam int DIFF_W  = 24;
  localparam int FRAC_W  = 32;
  localparam int DIV_N   = DIFF_W + FRAC_W;
  localparam int DIV_D   = 40;
  localparam int DIV_CW  = $clog2(DIV_N + 1);
  localparam int SUM_W   = 32;
  localparam int AVG_W   = 24;
  localparam int VALUE_W = 40;
  localparam int WEIGHT_W = 32;

  localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] SCALE_RESET = 40'd65536;
  localparam logic [AVG_W-1:0]   AVG_MAX     = 24'h7FFFFF;
  localparam logic [AVG_W-1:0]   AVG_MIN     = 24'h800000;
  localparam logic [7:0]         SAMPLES_RESET = 8'd10;
  localparam logic [1:0]         EXTRA_RESET   = 2'd1;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_EXTRA_PULSES = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_TARE = 2'd1,
    ACT_CAL  = 2'd2,
    ACT_MEAS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WEIGHT_ZERO = 2'd1,
    ST_SCALE_ZERO  = 2'd2
  } status_t;

  // Serial converter phase
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT       = 3'd1,
    PH_BIT_HIGH   = 3'd2,
    PH_BIT_LOW    = 3'd3,
    PH_EXTRA_HIGH = 3'd4,
    PH_EXTRA_LOW  = 3'd5
  } phase_t;

  // Per-word sequencer
  typedef enum logic [2:0] {
    SQ_READY  = 3'd0,
    SQ_STEP   = 3'd1,
    SQ_AVG_GO = 3'd2,
    SQ_AVG_DIV = 3'd3,
    SQ_Q_GO   = 3'd4,
    SQ_Q_DIV  = 3'd5,
    SQ_FINISH = 3'd6
  } seq_t;

  typedef enum logic [2:0] {
    OUT_TICK       = 3'd0,
    OUT_ERR_WEIGHT = 3'd1,
    OUT_TARE       = 3'd2,
    OUT_CAL        = 3'd3,
    OUT_MEAS       = 3'd4,
    OUT_SCALE_ZERO = 3'd5
  } out_sel_t;

  typedef enum logic {
    DIV_AVG = 1'b0,
    DIV_Q   = 1'b1
  } div_mode_t;

  typedef struct packed {
    logic      in_load;
    logic      run_start;
    logic      shift_clear;
    logic      shift_in;
    logic      bit_clear;
    logic      bit_inc;
    logic      sample_acc;
    logic      div_start;
    div_mode_t div_mode;
    logic      avg_load;
    logic      tare_load;
    logic      scale_load;
    logic      out_load;
    out_sel_t  out_sel;
    logic      clock_bit;
  } lcw_cmd_t;

  typedef struct packed {
    action_t action;
    logic    weight_zero;
    logic    data_bit;
    logic    bits_last;
    logic    extra_zero;
    logic    extra_last;
    logic    sample_last;
    logic    div_done;
    logic    scale_zero;
    action_t pend_action;
    logic    out_free;
  } lcw_stat_t;

endpackage

// ----- rtl/core/lcw_div.sv -----
// ----------------------------------------------------------------------------
// lcw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcw_div
  import lcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N-1:0]   dividend,
  input  logic [DIV_D-1:0]   divisor,
  output logic               busy,
  output logic               done,
  output logic [DIV_N-1:0]   quotient
);

  logic [DIV_D-1:0]  rem;
  logic [DIV_N-1:0]  quo;
  logic [DIV_D-1:0]  dsr;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_D:0]    shifted;
  logic [DIV_D+1:0]  trial;
  logic              fits;

  assign shifted  = {rem, quo[DIV_N-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dsr};
  assign fits     = ~trial[DIV_D+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
      cnt <= DIV_CW'(DIV_N);
    end else if (busy) begin
      rem <= fits ? trial[DIV_D-1:0] : shifted[DIV_D-1:0];
      quo <= {quo[DIV_N-2:0], fits};
      cnt <= cnt - DIV_CW'(1);
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

// ----- rtl/core/lcw_datapath.sv -----
// ----------------------------------------------------------------------------
// lcw_datapath
// Input and output registers, serial shifter, sample accumulator, tare and
// scale registers, and the shared divider.
// ----------------------------------------------------------------------------
module lcw_datapath
  import lcw_pkg::*;
#(
  parameter int DATA_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [39:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_data,
  input  lcw_cmd_t            cmd,
  output lcw_stat_t           st,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [71:0]         m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);

  localparam int BIT_W = $clog2(DATA_BITS + 1);

  // Config
  logic [7:0] sample_count;
  logic [1:0] extra_pulses;

  // Held input word
  action_t             in_action;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_data;

  // Run state
  logic [DATA_BITS-1:0] shift_value;
  logic [BIT_W-1:0]     bit_index;
  logic [7:0]           sample_index;
  logic [SUM_W-1:0]     sample_sum;
  action_t              pending_action;
  logic [WEIGHT_W-1:0]  pending_weight;
  logic [AVG_W-1:0]     tare_value;
  logic [VALUE_W-1:0]   scale_value;
  logic [AVG_W-1:0]     avg_value;

  // Output register
  logic                out_clock;
  logic                out_done;
  logic [1:0]          out_status;
  logic [AVG_W-1:0]    out_avg;
  logic [VALUE_W-1:0]  out_value;

  logic [DATA_BITS-1:0] shift_next;
  logic [SUM_W-1:0]   sample_ext;
  logic [7:0]         idx_inc;
  logic [7:0]         n_eff;
  logic [BIT_W:0]     bit_inc_w;
  logic               sum_neg;
  logic [SUM_W-1:0]   sum_mag;
  logic [SUM_W:0]     avg_full;
  logic [SUM_W-1:0]   avg_q;
  logic [AVG_W-1:0]   avg_sat;
  logic [AVG_W:0]     diff_s;
  logic [DIFF_W-1:0]  diff_mag;
  logic [DIV_N-1:0]   div_dividend;
  logic [DIV_D-1:0]   div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [DIV_N-1:0]   div_quot;
  logic [VALUE_W-1:0] q_sat;

  // Accumulate the sample including a last bit shifted in on the same tick
  assign shift_next = cmd.shift_in ? {shift_value[DATA_BITS-2:0], in_data} : shift_value;
  assign sample_ext = SUM_W'($signed(shift_next));
  assign idx_inc    = sample_index + 8'd1;
  assign n_eff      = (sample_count == 8'd0) ? 8'd1 : sample_count;
  assign bit_inc_w  = {1'b0, bit_index} + (BIT_W+1)'(1);

  // Truncating signed average from the unsigned quotient of magnitudes
  assign sum_neg  = sample_sum[SUM_W-1];
  assign sum_mag  = sum_neg ? (~sample_sum + SUM_W'(1)) : sample_sum;
  assign avg_q    = div_quot[SUM_W-1:0];
  assign avg_full = sum_neg ? (~{1'b0, avg_q} + (SUM_W+1)'(1)) : {1'b0, avg_q};

  always_comb begin
    if (!sum_neg && avg_q > SUM_W'(AVG_MAX)) begin
      avg_sat = AVG_MAX;
    end else if (sum_neg && avg_q > {{(SUM_W-AVG_W){1'b0}}, AVG_MIN}) begin
      avg_sat = AVG_MIN;
    end else begin
      avg_sat = avg_full[AVG_W-1:0];
    end
  end

  assign diff_s   = {avg_value[AVG_W-1], avg_value} - {tare_value[AVG_W-1], tare_value};
  assign diff_mag = diff_s[AVG_W] ? DIFF_W'(~diff_s + (AVG_W+1)'(1)) : diff_s[DIFF_W-1:0];

  always_comb begin
    if (cmd.div_mode == DIV_AVG) begin
      div_dividend = DIV_N'(sum_mag);
      div_divisor  = DIV_D'(n_eff);
    end else begin
      div_dividend = {diff_mag, {FRAC_W{1'b0}}};
      if (pending_action == ACT_CAL) begin
        div_divisor = (pending_weight == '0) ? DIV_D'(1) : DIV_D'(pending_weight);
      end else begin
        div_divisor = scale_value;
      end
    end
  end

  lcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign q_sat = (div_quot[DIV_N-1:VALUE_W] != '0) ? VALUE_MAX : div_quot[VALUE_W-1:0];

  always_comb begin
    st.action      = in_action;
    st.weight_zero = (in_weight == '0);
    st.data_bit    = in_data;
    st.bits_last   = (bit_index == BIT_W'(DATA_BITS - 1));
    st.extra_zero  = (extra_pulses == 2'd0);
    st.extra_last  = (bit_inc_w >= (BIT_W+1)'(extra_pulses));
    st.sample_last = (idx_inc == 8'd0) || (idx_inc >= n_eff);
    st.div_done    = div_done;
    st.scale_zero  = (scale_value == '0);
    st.pend_action = pending_action;
    st.out_free    = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLES_RESET;
      extra_pulses <= EXTRA_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLE_COUNT: sample_count <= cfg_data;
        CFG_EXTRA_PULSES: extra_pulses <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_action <= action_t'(s_tuser);
      in_weight <= s_tdata[WEIGHT_W-1:0];
      in_data   <= s_tdata[WEIGHT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value    <= '0;
      bit_index      <= '0;
      sample_index   <= '0;
      sample_sum     <= '0;
      pending_action <= ACT_TICK;
      pending_weight <= '0;
      tare_value     <= '0;
      scale_value    <= SCALE_RESET;
    end else begin
      if (cmd.run_start) begin
        pending_action <= in_action;
        pending_weight <= in_weight;
        sample_index   <= '0;
        sample_sum     <= '0;
      end else if (cmd.sample_acc) begin
        sample_sum   <= sample_sum + sample_ext;
        sample_index <= idx_inc;
      end
      if (cmd.run_start || cmd.shift_clear) begin
        shift_value <= '0;
      end else if (cmd.shift_in) begin
        shift_value <= shift_next;
      end
      if (cmd.run_start || cmd.bit_clear) begin
        bit_index <= '0;
      end else if (cmd.bit_inc) begin
        bit_index <= bit_inc_w[BIT_W-1:0];
      end
      if (cmd.tare_load) begin
        tare_value <= avg_value;
      end
      if (cmd.scale_load) begin
        scale_value <= q_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_load) begin
      avg_value <= avg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_clock  <= 1'b0;
      out_done   <= 1'b1;
      out_status <= ST_OK;
      out_avg    <= avg_value;
      out_value  <= '0;
      case (cmd.out_sel)
        OUT_TICK: begin
          out_clock <= cmd.clock_bit;
          out_done  <= 1'b0;
          out_avg   <= '0;
        end
        OUT_ERR_WEIGHT: begin
          out_status <= ST_WEIGHT_ZERO;
          out_avg    <= '0;
        end
        OUT_TARE: ;
        OUT_CAL:  out_value <= scale_value;
        OUT_MEAS: out_value <= q_sat;
        OUT_SCALE_ZERO: begin
          out_status <= ST_SCALE_ZERO;
          out_value  <= VALUE_MAX;
        end
        default: out_done <= 1'b0;
      endcase
    end
  end

  assign m_tdata = {7'd0, out_value, out_avg, out_clock};
  assign m_tuser = out_status;
  assign m_tlast = out_done;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("division started while one is running");

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sample_acc |-> (pending_action != ACT_TICK))
    else $error("sample accumulated outside a command run");

endmodule

// ----- rtl/core/lcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcw_ctrl
// Serial converter phase machine and per-word sequencer.
// ----------------------------------------------------------------------------
module lcw_ctrl
  import lcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  lcw_stat_t st,
  output lcw_cmd_t  cmd
);

  seq_t   seq, seq_next;
  phase_t phase, phase_next;
  logic   complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq   <= SQ_READY;
      phase <= PH_IDLE;
    end else begin
      seq   <= seq_next;
      phase <= phase_next;
    end
  end

  assign s_tready = (seq == SQ_READY);

  always_comb begin
    seq_next   = seq;
    phase_next = phase;
    cmd        = '0;
    complete   = 1'b0;
    cmd.div_mode = DIV_AVG;
    cmd.out_sel  = OUT_TICK;

    case (seq)
      SQ_READY: begin
        cmd.in_load = s_tvalid;
        if (s_tvalid) begin
          seq_next = SQ_STEP;
        end
      end

      SQ_STEP: begin
        // hold the tick until the output register can take its word
        if (st.out_free) begin
          case (phase)
            PH_WAIT: begin
              if (!st.data_bit) begin
                cmd.clock_bit   = 1'b1;
                cmd.shift_clear = 1'b1;
                cmd.bit_clear   = 1'b1;
                phase_next      = PH_BIT_LOW;
              end
            end
            PH_BIT_HIGH: begin
              cmd.clock_bit = 1'b1;
              phase_next    = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
              cmd.shift_in = 1'b1;
              if (st.bits_last) begin
                cmd.bit_clear = 1'b1;
                if (st.extra_zero) begin
                  cmd.sample_acc = 1'b1;
                  complete       = st.sample_last;
                  phase_next     = st.sample_last ? PH_IDLE : PH_WAIT;
                end else begin
                  phase_next = PH_EXTRA_HIGH;
                end
              end else begin
                cmd.bit_inc = 1'b1;
                phase_next  = PH_BIT_HIGH;
              end
            end
            PH_EXTRA_HIGH: begin
              cmd.clock_bit = 1'b1;
              phase_next    = PH_EXTRA_LOW;
            end
            PH_EXTRA_LOW: begin
              cmd.bit_inc = 1'b1;
              if (st.extra_last) begin
                cmd.sample_acc = 1'b1;
                complete       = st.sample_last;
                phase_next     = st.sample_last ? PH_IDLE : PH_WAIT;
              end else begin
                phase_next = PH_EXTRA_HIGH;
              end
            end
            default: begin
              phase_next = PH_IDLE;
              if (st.action == ACT_CAL && st.weight_zero) begin
                cmd.out_sel = OUT_ERR_WEIGHT;
              end else if (st.action != ACT_TICK) begin
                cmd.run_start = 1'b1;
                phase_next    = PH_WAIT;
              end
            end
          endcase
          if (complete) begin
            seq_next = SQ_AVG_GO;
          end else begin
            cmd.out_load = 1'b1;
            seq_next     = SQ_READY;
          end
        end
      end

      SQ_AVG_GO: begin
        cmd.div_start = 1'b1;
        seq_next      = SQ_AVG_DIV;
      end

      SQ_AVG_DIV: begin
        if (st.div_done) begin
          cmd.avg_load = 1'b1;
          seq_next     = SQ_Q_GO;
        end
      end

      SQ_Q_GO: begin
        cmd.div_mode = DIV_Q;
        if (st.pend_action == ACT_TARE) begin
          cmd.tare_load = 1'b1;
          seq_next      = SQ_FINISH;
        end else if (st.pend_action == ACT_MEAS && st.scale_zero) begin
          seq_next = SQ_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          seq_next      = SQ_Q_DIV;
        end
      end

      SQ_Q_DIV: begin
        cmd.div_mode = DIV_Q;
        if (st.div_done) begin
          cmd.scale_load = (st.pend_action == ACT_CAL);
          seq_next       = SQ_FINISH;
        end
      end

      SQ_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          seq_next     = SQ_READY;
          case (st.pend_action)
            ACT_TARE: cmd.out_sel = OUT_TARE;
            ACT_CAL:  cmd.out_sel = OUT_CAL;
            default:  cmd.out_sel = st.scale_zero ? OUT_SCALE_ZERO : OUT_MEAS;
          endcase
        end
      end

      default: seq_next = SQ_READY;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("output word overwritten before it was taken");

  a_idle_while_dividing: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_AVG_DIV || seq == SQ_Q_DIV) |-> (phase == PH_IDLE))
    else $error("converter phase active during result division");

  a_run_has_command: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_Q_GO) |-> (st.pend_action != ACT_TICK))
    else $error("command finished with no pending command");

endmodule

// ----- rtl/core/load_cell_weigh_controller.sv -----
// A plain tick's word is taken in SQ_READY and its result word loaded in SQ_STEP
// once the output is free. Finishing ticks run the 56-step shared divider for the
// average, and for calibrate and measure (scale nonzero) also for the quotient.
// No new word is taken until the last is done; a stalled output word holds the input off.
// Reset (synchronous, rst high) returns to idle with tare 0, scale 1.0,
// sample_count 10 and extra_pulses 1.
// ----------------------------------------------------------------------------
// load_cell_weigh_controller
// Bit-banged serial converter reader with averaging, tare, calibrate, measure.
// ----------------------------------------------------------------------------
module load_cell_weigh_controller
  import lcw_pkg::*;
#(
  parameter int DATA_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] ref_weight, [32] data_in, zero pad
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [0] clock_out, [24:1] average_raw, [64:25] value
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast,   // done_res
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data
);

  lcw_cmd_t  cmd;
  lcw_stat_t st;

  lcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lcw_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the load cell weigh controller. Every serial tick is
// predicted in the bench and checked word by word against the result stream.
// Converter data is shaped so that tare, calibrate and measure runs complete,
// under several register settings and sender and receiver idling profiles.
// ----------------------------------------------------------------------------
module tb_top
  import lcw_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    action_t     action;
    logic [31:0] ref_weight;
    logic        data_in;
  } weigh_tick_t;

  typedef struct packed {
    logic        clock_out;
    logic        done;
    status_t     status;
    logic [23:0] average_raw;
    logic [39:0] value;
  } weigh_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] ref_weight, [32] data_in, zero pad
  logic [1:0]  s_tuser = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [0] clock_out, [24:1] average_raw, [64:25] value
  logic [1:0]  m_tuser;        // [1:0] status
  logic        m_tlast;        // done_res
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_data = '0;

  load_cell_weigh_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  weigh_tick_t pending_ticks[$];
  weigh_word_t predicted_words[$];

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int stall_req  = 0;
  int stall_seen = 0;
  int hold_left  = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic s_word_taken = 1'b0;
  weigh_tick_t drive_word;
  weigh_word_t want_word;

  // Predicted weigher state and register copies
  phase_t             pred_phase = PH_IDLE;
  logic [4:0]         pred_bit = '0;
  logic [23:0]        pred_shift = '0;
  logic [7:0]         pred_conv_done = '0;
  logic [31:0]        pred_sum = '0;
  logic signed [23:0] pred_tare = '0;
  logic [39:0]        pred_scale = SCALE_RESET;
  action_t            pred_action = ACT_TICK;
  logic [31:0]        pred_weight = '0;
  logic [7:0]         conv_per_cmd = SAMPLES_RESET;
  logic [1:0]         extra_clocks = EXTRA_RESET;

  function automatic logic [39:0] q16_quotient(input longint unsigned diff,
                                               input longint unsigned divisor);
    longint unsigned q;
    q = (diff << 32) / divisor;
    return (q > 64'h00FF_FFFF_FFFF) ? VALUE_MAX : q[39:0];
  endfunction

  task automatic close_command(inout weigh_word_t r);
    longint sum_s;
    longint n;
    longint avg;
    longint d;
    longint unsigned diff;
    sum_s = longint'($signed(pred_sum));
    n = longint'(conv_per_cmd);
    if (n == 0) n = 1;
    avg = sum_s / n;
    if (avg > 64'sd8388607) avg = 64'sd8388607;
    if (avg < -64'sd8388608) avg = -64'sd8388608;
    d = avg - longint'(pred_tare);
    diff = (d < 0) ? -d : d;
    r.done = 1'b1;
    r.average_raw = avg[23:0];
    r.status = ST_OK;
    r.value = '0;
    if (pred_action == ACT_TARE) begin
      pred_tare = avg[23:0];
    end else if (pred_action == ACT_CAL) begin
      pred_scale = q16_quotient(diff, (pred_weight != 0) ? pred_weight : 32'd1);
      r.value = pred_scale;
    end else if (pred_scale == '0) begin
      r.status = ST_SCALE_ZERO;
      r.value = VALUE_MAX;
    end else begin
      r.value = q16_quotient(diff, pred_scale);
    end
    pred_phase = PH_IDLE;
  endtask

  task automatic close_conversion(inout weigh_word_t r);
    logic [7:0] n;
    n = (conv_per_cmd == 0) ? 8'd1 : conv_per_cmd;
    pred_sum = pred_sum + {{8{pred_shift[23]}}, pred_shift};
    pred_conv_done = pred_conv_done + 8'd1;
    if (pred_conv_done >= n || pred_conv_done == 0) close_command(r);
    else pred_phase = PH_WAIT;
  endtask

  task automatic weigher_tick(input weigh_tick_t t, output weigh_word_t r);
    r = '0;
    case (pred_phase)
      PH_WAIT: begin
        if (!t.data_in) begin
          r.clock_out = 1'b1;
          pred_bit = '0;
          pred_shift = '0;
          pred_phase = PH_BIT_LOW;
        end
      end
      PH_BIT_HIGH: begin
        r.clock_out = 1'b1;
        pred_phase = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        pred_shift = {pred_shift[22:0], t.data_in};
        pred_bit = pred_bit + 5'd1;
        if (pred_bit >= 5'd24) begin
          pred_bit = '0;
          if (extra_clocks == 0) close_conversion(r);
          else pred_phase = PH_EXTRA_HIGH;
        end else begin
          pred_phase = PH_BIT_HIGH;
        end
      end
      PH_EXTRA_HIGH: begin
        r.clock_out = 1'b1;
        pred_phase = PH_EXTRA_LOW;
      end
      PH_EXTRA_LOW: begin
        pred_bit = pred_bit + 5'd1;
        if (pred_bit >= {3'd0, extra_clocks}) close_conversion(r);
        else pred_phase = PH_EXTRA_HIGH;
      end
      default: begin
        pred_phase = PH_IDLE;
        if (t.action == ACT_CAL && t.ref_weight == 0) begin
          r.done = 1'b1;
          r.status = ST_WEIGHT_ZERO;
        end else if (t.action != ACT_TICK) begin
          pred_action = t.action;
          pred_weight = t.ref_weight;
          pred_conv_done = '0;
          pred_sum = '0;
          pred_bit = '0;
          pred_shift = '0;
          pred_phase = PH_WAIT;
        end
      end
    endcase
  endtask

  task automatic push_tick(input action_t a, input logic [31:0] w, input logic d);
    weigh_tick_t t;
    weigh_word_t r;
    t.action = a;
    t.ref_weight = w;
    t.data_in = d;
    weigher_tick(t, r);
    predicted_words.push_back(r);
    pending_ticks.push_back(t);
  endtask

  function automatic logic [23:0] pick_sample();
    logic [23:0] v;
    v = 24'($urandom());
    case ($urandom_range(7))
      0: v = 24'h7FFFFF;
      1: v = 24'h800000;
      2: v = 24'h000000;
      3: v = 24'hFFFFFF;
      4, 5: v = 24'($urandom_range(2000)) - 24'd1000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_weight();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0: w = 32'd0;
      1: w = 32'd1;
      2: w = 32'hFFFFFFFF;
      3: w = 32'h00010000;
      4, 5: w = {4'd0, 12'($urandom_range(4095)), 16'($urandom())};
      default: ;
    endcase
    return w;
  endfunction

  // Play the converter for one command until the weigher is idle again
  task automatic run_command(input action_t a, input logic [31:0] w,
                             input bit fixed, input logic [23:0] fixed_val);
    logic d;
    logic [23:0] conv;
    conv = '0;
    push_tick(a, w, 1'($urandom_range(1)));
    while (pred_phase != PH_IDLE) begin
      case (pred_phase)
        PH_WAIT: begin
          d = ($urandom_range(2) != 0);
          if (!d) conv = fixed ? fixed_val : pick_sample();
        end
        PH_BIT_LOW: d = conv[23 - pred_bit];
        default: d = 1'($urandom_range(1));
      endcase
      // commands offered while busy must be dropped
      push_tick(action_t'($urandom_range(3)), $urandom(), d);
    end
  endtask

  task automatic random_command();
    action_t a;
    a = action_t'($urandom_range(1, 3));
    run_command(a, (a == ACT_CAL) ? pick_weight() : $urandom(), 1'b0, '0);
    repeat ($urandom_range(3)) push_tick(ACT_TICK, $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || predicted_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] val);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_addr = addr;
    cfg_data = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == CFG_SAMPLE_COUNT) conv_per_cmd = val;
    else extra_clocks = val[1:0];
  endtask

  task automatic set_profile(input int k);
    case (k)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
      default: begin src_idle_pct = 38; sink_stall_pct = 38; end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: hold the word until taken, then offer the next or idle
  always @(posedge clk) s_word_taken <= s_tvalid && s_tready;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_word_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_word = pending_ticks.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, drive_word.data_in, drive_word.ref_weight};
        s_tuser <= drive_word.action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_words.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want_word = predicted_words.pop_front();
        compare_field("clock_out", 40'(want_word.clock_out), 40'(m_tdata[0]));
        compare_field("done_res", 40'(want_word.done), 40'(m_tlast));
        compare_field("status", 40'(want_word.status), 40'(m_tuser));
        compare_field("average_raw", 40'(want_word.average_raw), 40'(m_tdata[24:1]));
        compare_field("value", want_word.value, m_tdata[64:25]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t stream stalled", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every command and the corner cases
    set_profile(0);
    write_reg(CFG_SAMPLE_COUNT, 8'd1);
    write_reg(CFG_EXTRA_PULSES, 8'd1);
    push_tick(ACT_TICK, 32'hFFFFFFFF, 1'b1);
    run_command(ACT_TARE, 32'h0, 1'b1, 24'h000000);
    run_command(ACT_CAL, 32'h0, 1'b1, 24'h000000);          // zero weight error
    run_command(ACT_CAL, 32'h00010000, 1'b1, 24'h000000);   // zero diff, zero scale
    run_command(ACT_MEAS, 32'h0, 1'b1, 24'h7FFFFF);         // scale zero flagged

    wait_drained();
    set_profile(1);
    run_command(ACT_CAL, 32'hFFFFFFFF, 1'b1, 24'h000001);   // smallest scale
    run_command(ACT_MEAS, 32'h0, 1'b1, 24'h800000);         // weight saturates
    run_command(ACT_CAL, 32'h00010000, 1'b1, 24'hFFFFFF);   // back to unity

    wait_drained();
    set_profile(2);
    run_command(ACT_TARE, 32'hFFFFFFFF, 1'b1, 24'h800000);
    run_command(ACT_CAL, 32'h1, 1'b1, 24'h7FFFFF);          // scale saturates
    run_command(ACT_MEAS, 32'h0, 1'b1, 24'h7FFFFF);
    // back-pressure: block the output while the sender keeps offering
    stall_req = stall_req + 1;

    // Random: register corners with both sides idling
    write_reg(CFG_EXTRA_PULSES, 8'd0);
    write_reg(CFG_SAMPLE_COUNT, 8'd2);
    set_profile(3);
    random_command();
    write_reg(CFG_EXTRA_PULSES, 8'd3);
    write_reg(CFG_SAMPLE_COUNT, 8'd0);
    random_command();

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && predicted_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
